### hw/rtl/twmn_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// twmn_pkg
// Shared types and constants of the tree wave minimum node.
// ----------------------------------------------------------------------------
package twmn_pkg;

    localparam int unsigned ID_W       = 4;
    localparam int unsigned VAL_W      = 32;
    localparam int unsigned DEG_W      = 3;
    localparam int unsigned CNT_W      = 3;
    localparam int unsigned TABLE_W    = 16;
    localparam int unsigned APB_DW     = 32;
    localparam int unsigned PADDR_W    = 4;
    localparam int unsigned RESULT_CAP = 4;
    localparam int unsigned ECNT_W     = $clog2(RESULT_CAP);

    localparam int unsigned MAX_NEIGHBORS_DEF = 4;
    localparam int unsigned NODE_ID_BITS_DEF  = 4;

    localparam logic [DEG_W-1:0] DEGREE_RST = 3'd1;
    localparam logic [CNT_W-1:0] CNT_MAX    = 3'd7;

    // register map, word index
    localparam logic [1:0] REG_DEGREE = 2'd0;
    localparam logic [1:0] REG_TABLE  = 2'd1;
    localparam logic [1:0] REG_LOCAL  = 2'd2;

    // message kinds
    localparam logic KIND_INIT = 1'b0;
    localparam logic KIND_RESP = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_EVAL = 3'b010,
        S_SEND = 3'b100
    } t_state;

    typedef struct packed {
        logic capture;
        logic eval;
        logic load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic out_free;
        logic last;
    } t_dp_sts;

endpackage

### hw/rtl/twmn_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// twmn_ctrl
// Sequencer: takes one item, evaluates it, then hands its results to the
// output register one per transfer.
// ----------------------------------------------------------------------------
module twmn_ctrl
    import twmn_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    output t_dp_cmd o_cmd,
    input  t_dp_sts i_sts
);

    t_state r_state;
    t_state n_state;

    assign o_in_ready     = (r_state == S_IDLE);
    assign o_cmd.capture  = i_in_valid && (r_state == S_IDLE);
    assign o_cmd.eval     = (r_state == S_EVAL);
    assign o_cmd.load_out = (r_state == S_SEND) && i_sts.out_free;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_EVAL;
            end
            S_EVAL: begin
                n_state = S_SEND;
            end
            S_SEND: begin
                if (i_sts.out_free && i_sts.last) n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

### hw/rtl/twmn_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// twmn_dp
// Datapath: configuration registers, node state, item evaluation, pending
// send mask and the output register.
// ----------------------------------------------------------------------------
module twmn_dp
    import twmn_pkg::*;
#(
    parameter int unsigned MAX_NEIGHBORS = MAX_NEIGHBORS_DEF,
    parameter int unsigned NODE_ID_BITS  = NODE_ID_BITS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // configuration
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [PADDR_W-1:0]        paddr,
    input  logic [APB_DW-1:0]         pwdata,
    output logic [APB_DW-1:0]         prdata,
    // input item
    input  logic                      i_action,
    input  logic                      i_msg_kind,
    input  logic [ID_W-1:0]           i_source_node,
    input  logic signed [VAL_W-1:0]   i_msg_value,
    // result item
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic                      o_send_valid,
    output logic [ID_W-1:0]           o_dest_node,
    output logic                      o_out_kind,
    output logic signed [VAL_W-1:0]   o_out_value,
    output logic                      o_finished,
    output logic                      o_is_decider,
    output logic                      o_last_of_run,
    // control
    input  t_dp_cmd                   i_cmd,
    output t_dp_sts                   o_sts
);

    localparam int unsigned NB  = MAX_NEIGHBORS;
    localparam int unsigned NIB = NODE_ID_BITS;

    // configuration
    logic [DEG_W-1:0]         r_degree;
    logic [TABLE_W-1:0]       r_table;
    logic signed [VAL_W-1:0]  r_local;

    // node state
    logic signed [VAL_W-1:0]  r_min;
    logic [NB-1:0]            r_flags;
    logic [CNT_W-1:0]         r_cnt;
    logic                     r_init_sent;
    logic                     r_done;
    logic                     r_decider;

    // captured item
    logic                     r_action;
    logic                     r_kind;
    logic [NIB-1:0]           r_src;
    logic signed [VAL_W-1:0]  r_val;

    // pending results
    logic [NB-1:0]            r_mask;
    logic                     r_pkind;
    logic                     r_status;
    logic [ECNT_W-1:0]        r_ecnt;

    // output register
    logic                     r_out_valid;
    logic                     r_send_valid;
    logic [ID_W-1:0]          r_dest;
    logic                     r_out_kind;
    logic signed [VAL_W-1:0]  r_out_value;
    logic                     r_finished;
    logic                     r_is_decider;
    logic                     r_last;

    logic                     w_wr;
    logic [NIB-1:0]           w_slot [NB];
    logic [DEG_W-1:0]         w_deg;
    logic [NB-1:0]            w_below;
    logic [NB-1:0]            w_match;
    logic                     w_msg;
    logic [CNT_W-1:0]         w_cnt_n;
    logic signed [VAL_W-1:0]  w_min_n;
    logic [NB-1:0]            w_flags_n;
    logic                     w_resp;
    logic                     w_decide;
    logic                     w_done_n;
    logic [NB-1:0]            w_unheard;
    logic [NB-1:0]            w_init_pick;
    logic                     w_try_init;
    logic                     w_send_init;
    logic [NB-1:0]            w_mask_n;
    logic [NB-1:0]            w_lowest;
    logic [NB-1:0]            w_rest;
    logic [NIB-1:0]           w_dest;
    logic                     w_last;

    assign w_wr = psel && penable && pwrite;

    always_comb begin
        case (paddr[3:2])
            REG_DEGREE: prdata = APB_DW'(r_degree);
            REG_TABLE:  prdata = APB_DW'(r_table);
            REG_LOCAL:  prdata = r_local;
            default:    prdata = '0;
        endcase
    end

    for (genvar g = 0; g < NB; g++) begin : g_slot
        localparam int unsigned SH = g * NIB;
        assign w_slot[g]  = NIB'(64'(r_table) >> SH);
        assign w_below[g] = (4'(g) < {1'b0, w_deg});
        assign w_match[g] = w_below[g] && (w_slot[g] == r_src);
    end

    assign w_deg = ({1'b0, r_degree} > 4'(NB)) ? DEG_W'(NB) : r_degree;

    // item evaluation
    assign w_msg     = !r_done && r_action;
    assign w_cnt_n   = !w_msg ? r_cnt : ((r_cnt == CNT_MAX) ? CNT_MAX : r_cnt + 1'b1);
    assign w_min_n   = (w_msg && (r_val < r_min)) ? r_val : r_min;
    assign w_flags_n = (w_msg && r_kind == KIND_INIT) ? (r_flags | w_match) : r_flags;
    assign w_decide  = w_msg && (r_kind == KIND_INIT) && (w_cnt_n == w_deg);
    assign w_resp    = w_msg && ((r_kind == KIND_RESP) || (w_cnt_n == w_deg));
    assign w_done_n  = r_done || w_resp;
    assign w_unheard = w_below & ~w_flags_n;
    assign w_try_init = !w_done_n && !r_init_sent && (w_deg != '0)
                        && (({1'b0, w_cnt_n} + 4'd1) >= {1'b0, w_deg});
    assign w_send_init = w_try_init && (w_unheard != '0);

    // init goes to the highest silent slot
    always_comb begin
        logic seen;
        seen = 1'b0;
        for (int i = NB - 1; i >= 0; i--) begin
            w_init_pick[i] = w_unheard[i] && !seen;
            seen           = seen || w_unheard[i];
        end
    end

    assign w_mask_n = w_resp ? (w_below & ~w_match)
                    : (w_send_init ? w_init_pick : '0);

    // result emission, lowest pending slot first
    assign w_lowest = r_mask & (~r_mask + NB'(1));
    assign w_rest   = r_mask & ~w_lowest;
    assign w_last   = r_status || (w_rest == '0) || (r_ecnt == ECNT_W'(RESULT_CAP - 1));

    always_comb begin
        w_dest = '0;
        for (int i = 0; i < NB; i++) begin
            if (w_lowest[i]) w_dest = w_dest | w_slot[i];
        end
    end

    assign o_sts.out_free = !r_out_valid || i_out_ready;
    assign o_sts.last     = w_last;

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_degree    <= DEGREE_RST;
            r_table     <= '0;
            r_local     <= '0;
            r_min       <= '0;
            r_flags     <= '0;
            r_cnt       <= '0;
            r_init_sent <= 1'b0;
            r_done      <= 1'b0;
            r_decider   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.eval) begin
                r_min       <= w_min_n;
                r_flags     <= w_flags_n;
                r_cnt       <= w_cnt_n;
                r_done      <= w_done_n;
                r_decider   <= r_decider || w_decide;
                r_init_sent <= r_init_sent || w_send_init;
            end
            if (w_wr) begin
                case (paddr[3:2])
                    REG_DEGREE: r_degree <= pwdata[DEG_W-1:0];
                    REG_TABLE:  r_table  <= pwdata[TABLE_W-1:0];
                    REG_LOCAL: begin
                        r_local <= pwdata;
                        r_min   <= pwdata;
                    end
                    default: ;
                endcase
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_action <= i_action;
            r_kind   <= i_msg_kind;
            r_src    <= NIB'(i_source_node);
            r_val    <= i_msg_value;
        end
        if (i_cmd.eval) begin
            r_mask   <= w_mask_n;
            r_pkind  <= w_resp ? KIND_RESP : KIND_INIT;
            r_status <= (w_mask_n == '0);
            r_ecnt   <= '0;
        end
        if (i_cmd.load_out) begin
            r_send_valid <= !r_status;
            r_dest       <= r_status ? '0 : ID_W'(w_dest);
            r_out_kind   <= r_status ? KIND_INIT : r_pkind;
            r_out_value  <= r_min;
            r_finished   <= r_done;
            r_is_decider <= r_decider;
            r_last       <= w_last;
            r_mask       <= w_rest;
            r_ecnt       <= r_ecnt + 1'b1;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_send_valid  = r_send_valid;
    assign o_dest_node   = r_dest;
    assign o_out_kind    = r_out_kind;
    assign o_out_value   = r_out_value;
    assign o_finished    = r_finished;
    assign o_is_decider  = r_is_decider;
    assign o_last_of_run = r_last;

endmodule

### hw/rtl/tree_wave_minimum_node.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tree_wave_minimum_node
// One node of the tree wave minimum algorithm: folds message values into a
// running minimum, sends init to the last silent neighbor, then decides or
// forwards responses and finishes.
// ----------------------------------------------------------------------------
// An item is captured in the idle state and evaluated in the eval state, and
// its results (one to four results) then leave one per transfer through a
// single output register, each held there while the output stalls; the next
// item is taken once the last result of the current one is in the output
// register. The user must write configuration over APB only while the node is idle; the block does not enforce this.
module tree_wave_minimum_node
    import twmn_pkg::*;
#(
    parameter int unsigned MAX_NEIGHBORS = MAX_NEIGHBORS_DEF,
    parameter int unsigned NODE_ID_BITS  = NODE_ID_BITS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [PADDR_W-1:0]        paddr,
    input  logic [APB_DW-1:0]         pwdata,
    output logic [APB_DW-1:0]         prdata,
    output logic                      pready,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  logic                      i_action,
    input  logic                      i_msg_kind,
    input  logic [ID_W-1:0]           i_source_node,
    input  logic signed [VAL_W-1:0]   i_msg_value,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic                      o_send_valid,
    output logic [ID_W-1:0]           o_dest_node,
    output logic                      o_out_kind,
    output logic signed [VAL_W-1:0]   o_out_value,
    output logic                      o_finished,
    output logic                      o_is_decider,
    output logic                      o_last_of_run
);

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    assign pready = 1'b1;

    twmn_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .o_cmd      (w_cmd),
        .i_sts      (w_sts)
    );

    twmn_dp #(
        .MAX_NEIGHBORS (MAX_NEIGHBORS),
        .NODE_ID_BITS  (NODE_ID_BITS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .i_action      (i_action),
        .i_msg_kind    (i_msg_kind),
        .i_source_node (i_source_node),
        .i_msg_value   (i_msg_value),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_send_valid  (o_send_valid),
        .o_dest_node   (o_dest_node),
        .o_out_kind    (o_out_kind),
        .o_out_value   (o_out_value),
        .o_finished    (o_finished),
        .o_is_decider  (o_is_decider),
        .o_last_of_run (o_last_of_run),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts)
    );

endmodule

### hw/rtl/twmn_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// twmn_checker
// Port-level checks of the tree wave minimum node, bound to the top level.
// ----------------------------------------------------------------------------
module twmn_checker
    import twmn_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              o_out_valid,
    input logic              i_out_ready,
    input logic              o_send_valid,
    input logic [ID_W-1:0]   o_dest_node,
    input logic              o_out_kind,
    input logic              o_finished,
    input logic              o_is_decider,
    input logic              o_last_of_run
);

    // result holds until its transfer
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result dropped before transfer");

    // finished never clears
    a_finished_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_finished |=> !o_out_valid || o_finished)
        else $error("finished flag cleared");

    a_decider_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_is_decider |-> o_finished)
        else $error("decider without finished");

    a_status_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_send_valid |->
            o_dest_node == '0 && o_out_kind == KIND_INIT && o_last_of_run)
        else $error("malformed status result");

    // init is the only send of its item and never comes from a finished node
    a_init_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_send_valid && o_out_kind == KIND_INIT |->
            !o_finished && o_last_of_run)
        else $error("init sent with other results or after finishing");

endmodule

bind tree_wave_minimum_node twmn_checker u_twmn_checker (.*);

### tb/sv/twmn_check_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// twmn_check_pkg
// Result record and scoreboard for the tree wave minimum node bench. The
// scoreboard keeps its own copy of the node registers and wave state, works
// out the sends of every accepted transfer and checks the node's results
// against them in order.
// ----------------------------------------------------------------------------
package twmn_check_pkg;

    import twmn_pkg::*;

    typedef struct {
        logic                    send;
        logic [ID_W-1:0]         dest;
        logic                    kind;
        logic signed [VAL_W-1:0] value;
        logic                    finished;
        logic                    decider;
        logic                    last;
    } wave_out_t;

    class min_wave_scoreboard;

        logic [DEG_W-1:0]             degree_r;
        logic [TABLE_W-1:0]           table_r;
        logic [MAX_NEIGHBORS_DEF-1:0] heard;
        logic [CNT_W-1:0]             msg_count;
        logic signed [VAL_W-1:0]      run_min;
        logic [ID_W-1:0]              last_src;
        logic                         last_src_ok;
        logic                         init_done;
        logic                         finished;
        logic                         decider;
        wave_out_t                    item_sends[$];
        wave_out_t                    queued_sends[$];
        int unsigned                  mismatches;

        function new();
            degree_r     = DEGREE_RST;
            table_r      = '0;
            heard        = '0;
            msg_count    = '0;
            run_min      = '0;
            last_src     = '0;
            last_src_ok  = 1'b0;
            init_done    = 1'b0;
            finished     = 1'b0;
            decider      = 1'b0;
            mismatches   = 0;
        endfunction

        function int unsigned live_degree();
            return (32'(degree_r) > MAX_NEIGHBORS_DEF) ? MAX_NEIGHBORS_DEF : 32'(degree_r);
        endfunction

        function logic [ID_W-1:0] slot_node(int unsigned i);
            return table_r[i*ID_W +: ID_W];
        endfunction

        function int unsigned pending();
            return queued_sends.size();
        endfunction

        function void write_reg(logic [1:0] idx, logic [APB_DW-1:0] data);
            case (idx)
                REG_DEGREE: degree_r = data[DEG_W-1:0];
                REG_TABLE:  table_r  = data[TABLE_W-1:0];
                REG_LOCAL:  run_min  = data[VAL_W-1:0];
                default: ;
            endcase
        endfunction

        function void add_send(logic send, logic [ID_W-1:0] dest, logic kind);
            wave_out_t r;
            r.send     = send;
            r.dest     = dest;
            r.kind     = kind;
            r.value    = '0;
            r.finished = 1'b0;
            r.decider  = 1'b0;
            r.last     = 1'b0;
            if (item_sends.size() < RESULT_CAP) item_sends.push_back(r);
        endfunction

        // response to every neighbor but the last sender, then done
        function void answer_neighbors();
            for (int unsigned i = 0; i < live_degree(); i++) begin
                if (!(last_src_ok && slot_node(i) == last_src)) begin
                    add_send(1'b1, slot_node(i), KIND_RESP);
                end
            end
            finished = 1'b1;
        endfunction

        function void note_item(logic act, logic kind, logic [ID_W-1:0] src,
                                logic signed [VAL_W-1:0] val);
            int unsigned     d;
            logic [ID_W-1:0] dest;
            logic            found;
            d = live_degree();
            item_sends.delete();
            if (!finished) begin
                if (act) begin
                    if (msg_count != CNT_MAX) msg_count = msg_count + 1'b1;
                    last_src    = src;
                    last_src_ok = 1'b1;
                    if (val < run_min) run_min = val;
                    if (kind == KIND_INIT) begin
                        for (int unsigned i = 0; i < d; i++) begin
                            if (slot_node(i) == src) heard[i] = 1'b1;
                        end
                        if (32'(msg_count) == d) begin
                            decider = 1'b1;
                            answer_neighbors();
                        end
                    end else begin
                        answer_neighbors();
                    end
                end
                if (!finished && !init_done && d > 0 && 32'(msg_count) + 1 >= d) begin
                    found = 1'b0;
                    dest  = '0;
                    for (int unsigned i = 0; i < d; i++) begin
                        if (!heard[i]) begin
                            dest  = slot_node(i);
                            found = 1'b1;
                        end
                    end
                    if (found) begin
                        add_send(1'b1, dest, KIND_INIT);
                        init_done = 1'b1;
                    end
                end
            end
            if (item_sends.size() == 0) add_send(1'b0, '0, KIND_INIT);
            foreach (item_sends[k]) begin
                item_sends[k].value    = run_min;
                item_sends[k].finished = finished;
                item_sends[k].decider  = decider;
                item_sends[k].last     = (k == item_sends.size() - 1);
                queued_sends.push_back(item_sends[k]);
            end
        endfunction

        task report_mismatch(string what);
            mismatches++;
            if (mismatches <= 40) $display("%0t ns  twmn mismatch: %s", $time, what);
        endtask

        task check_result(wave_out_t got);
            wave_out_t want;
            if (queued_sends.size() == 0) begin
                report_mismatch($sformatf("unexpected result, dest %0d value %0d",
                                          got.dest, got.value));
                return;
            end
            want = queued_sends.pop_front();
            if (got.send !== want.send)
                report_mismatch($sformatf("send_valid %b, want %b", got.send, want.send));
            if (got.dest !== want.dest)
                report_mismatch($sformatf("dest_node %0d, want %0d", got.dest, want.dest));
            if (got.kind !== want.kind)
                report_mismatch($sformatf("out_kind %b, want %b", got.kind, want.kind));
            if (got.value !== want.value)
                report_mismatch($sformatf("out_value %0d, want %0d", got.value, want.value));
            if (got.finished !== want.finished)
                report_mismatch($sformatf("finished %b, want %b", got.finished,
                                          want.finished));
            if (got.decider !== want.decider)
                report_mismatch($sformatf("is_decider %b, want %b", got.decider,
                                          want.decider));
            if (got.last !== want.last)
                report_mismatch($sformatf("last_of_run %b, want %b", got.last, want.last));
        endtask

    endclass

endpackage

### tb/sv/tree_wave_minimum_node_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tree_wave_minimum_node_test
// Self-checking bench for one tree wave minimum node. Registers are set over
// APB while the node is idle; message transfers go in with random gaps and
// results come out under random stalls, each checked field by field against
// the scoreboard. Each run ends the wave either by deciding or by forwarding
// a response, picked by the seed, and then checks that the node stays done.
// ----------------------------------------------------------------------------
module tree_wave_minimum_node_test;

    import twmn_pkg::*;
    import twmn_check_pkg::*;

    localparam int unsigned RAND_ITEMS = 90;
    localparam int unsigned LIMIT_NS   = 2_000_000;

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    psel;
    logic                    penable;
    logic                    pwrite;
    logic [PADDR_W-1:0]      paddr;
    logic [APB_DW-1:0]       pwdata;
    logic [APB_DW-1:0]       prdata;
    logic                    pready;
    logic                    i_in_valid;
    logic                    o_in_ready;
    logic                    i_action;
    logic                    i_msg_kind;
    logic [ID_W-1:0]         i_source_node;
    logic signed [VAL_W-1:0] i_msg_value;
    logic                    o_out_valid;
    logic                    i_out_ready;
    logic                    o_send_valid;
    logic [ID_W-1:0]         o_dest_node;
    logic                    o_out_kind;
    logic signed [VAL_W-1:0] o_out_value;
    logic                    o_finished;
    logic                    o_is_decider;
    logic                    o_last_of_run;

    bit                      calm;
    bit                      fwd_mode;
    min_wave_scoreboard      sb = new();

    tree_wave_minimum_node u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_action      (i_action),
        .i_msg_kind    (i_msg_kind),
        .i_source_node (i_source_node),
        .i_msg_value   (i_msg_value),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_send_valid  (o_send_valid),
        .o_dest_node   (o_dest_node),
        .o_out_kind    (o_out_kind),
        .o_out_value   (o_out_value),
        .o_finished    (o_finished),
        .o_is_decider  (o_is_decider),
        .o_last_of_run (o_last_of_run)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #(LIMIT_NS);
        $display("[tree_wave_minimum_node] ERROR");
        $finish;
    end

    function automatic logic signed [VAL_W-1:0] pick_value();
        case ($urandom_range(0, 7))
            0: return {1'b1, {(VAL_W-1){1'b0}}};
            1: return {1'b0, {(VAL_W-1){1'b1}}};
            2: return '0;
            3: return '1;
            default: return VAL_W'($urandom);
        endcase
    endfunction

    function automatic logic [TABLE_W-1:0] pick_table();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            2: return {MAX_NEIGHBORS_DEF{ID_W'($urandom)}};
            default: return TABLE_W'($urandom);
        endcase
    endfunction

    function automatic logic [ID_W-1:0] pick_source();
        if ($urandom_range(0, 1) == 1) return sb.slot_node($urandom_range(0, 3));
        return ID_W'($urandom);
    endfunction

    task automatic reg_write(input logic [1:0] idx, input logic [APB_DW-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        sb.write_reg(idx, data);
    endtask

    task automatic bus_release();
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic push_item(input logic act, input logic kind, input logic [ID_W-1:0] src,
                             input logic signed [VAL_W-1:0] val);
        int unsigned gap;
        gap = calm ? 0 : $urandom_range(0, 6);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_action      <= act;
        i_msg_kind    <= kind;
        i_source_node <= src;
        i_msg_value   <= val;
        do @(posedge i_clk); while (o_in_ready !== 1'b1);
        sb.note_item(act, kind, src, val);
    endtask

    task automatic settle();
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    initial begin : result_sink
        int unsigned stall;
        wave_out_t   got;
        i_out_ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            stall = calm ? 0 : $urandom_range(0, 6);
            if (stall != 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!(o_out_valid === 1'b1 && i_out_ready === 1'b1));
            got.send     = o_send_valid;
            got.dest     = o_dest_node;
            got.kind     = o_out_kind;
            got.value    = o_out_value;
            got.finished = o_finished;
            got.decider  = o_is_decider;
            got.last     = o_last_of_run;
            sb.check_result(got);
        end
    end

    initial begin : stimulus
        int unsigned n_rand;
        int unsigned run_len;
        i_rst_n       <= 1'b0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        i_in_valid    <= 1'b0;
        i_action      <= 1'b0;
        i_msg_kind    <= KIND_INIT;
        i_source_node <= '0;
        i_msg_value   <= '0;
        fwd_mode = 1'($urandom_range(0, 1));
        calm     = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // degree zero: values fold in, nothing is sent
        reg_write(REG_DEGREE, '0);
        reg_write(REG_TABLE, APB_DW'(pick_table()));
        reg_write(REG_LOCAL, APB_DW'(pick_value()));
        bus_release();
        push_item(1'b0, KIND_RESP, 4'hF, {1'b0, {(VAL_W-1){1'b1}}});
        push_item(1'b1, KIND_INIT, 4'hF, {1'b0, {(VAL_W-1){1'b1}}});
        push_item(1'b1, KIND_INIT, 4'h0, {1'b1, {(VAL_W-1){1'b0}}});
        settle();

        // both slots name node 5: one init leaves no silent neighbor
        reg_write(REG_DEGREE, APB_DW'(2));
        reg_write(REG_TABLE, APB_DW'({8'($urandom), 4'h5, 4'h5}));
        bus_release();
        push_item(1'b1, KIND_INIT, 4'h5, VAL_W'($urandom));
        push_item(1'b0, KIND_INIT, 4'h0, '0);
        if (fwd_mode) begin
            push_item(1'b1, KIND_INIT, 4'h5, '1);
            settle();
            // degree above the limit, count runs into saturation
            reg_write(REG_DEGREE, APB_DW'(7));
            reg_write(REG_LOCAL, APB_DW'({1'b0, {(VAL_W-1){1'b1}}}));
            bus_release();
            push_item(1'b1, KIND_INIT, 4'h0, '0);
            push_item(1'b1, KIND_INIT, 4'hF, '1);
            push_item(1'b1, KIND_INIT, pick_source(), VAL_W'($urandom));
            push_item(1'b1, KIND_INIT, pick_source(), {1'b1, {(VAL_W-1){1'b0}}});
        end else begin
            settle();
            reg_write(REG_LOCAL, APB_DW'({1'b1, {(VAL_W-1){1'b0}}}));
            bus_release();
            push_item(1'b0, KIND_RESP, 4'hA, '1);
        end
        settle();

        n_rand = 0;
        while (n_rand < RAND_ITEMS) begin
            if ($urandom_range(0, 1) == 1) reg_write(REG_DEGREE, APB_DW'($urandom_range(0, 7)));
            if ($urandom_range(0, 1) == 1) reg_write(REG_TABLE, APB_DW'(pick_table()));
            if ($urandom_range(0, 2) == 0) reg_write(REG_LOCAL, APB_DW'(pick_value()));
            bus_release();
            calm    = ($urandom_range(0, 3) == 0);
            run_len = $urandom_range(8, 20);
            repeat (run_len) begin
                // a saturated count never matches the degree, so inits are safe here
                if (fwd_mode && $urandom_range(0, 99) < 65) begin
                    push_item(1'b1, KIND_INIT, pick_source(), pick_value());
                end else begin
                    push_item(1'b0, 1'($urandom_range(0, 1)), ID_W'($urandom), pick_value());
                end
                n_rand++;
            end
            settle();
        end

        // close the wave, then the node must ignore everything
        reg_write(REG_DEGREE, APB_DW'(fwd_mode ? $urandom_range(0, 7) : $urandom_range(4, 7)));
        reg_write(REG_TABLE, APB_DW'(pick_table()));
        bus_release();
        calm = 1'b0;
        push_item(1'b1, fwd_mode ? KIND_RESP : KIND_INIT, pick_source(), pick_value());
        repeat (6) begin
            push_item(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), ID_W'($urandom),
                      pick_value());
        end
        settle();
        repeat (20) @(posedge i_clk);

        if (sb.mismatches == 0) begin
            $display("[tree_wave_minimum_node] OK");
        end else begin
            $display("[tree_wave_minimum_node] ERROR");
        end
        $finish;
    end

endmodule
